// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// cond must hold at every clock edge outside reset
`define RTMF_CHECK(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: condition");

// ante at one edge implies cons at the next edge
`define RTMF_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define RTMF_CHECK(name, clk, rst, cond)
`define RTMF_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== design/rtmf_pkg.sv =====
// ----------------------------------------------------------------------------
// rtmf_pkg
// Shared types, codes and the mask builder of the route table.
// ----------------------------------------------------------------------------
`default_nettype none

package rtmf_pkg;

   typedef enum logic [1:0] {
      OP_SET  = 2'd0,
      OP_DEL  = 2'd1,
      OP_LOOK = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   // one stored route
   typedef struct packed {
      logic [31:0] net;
      logic [31:0] mask;
      logic [31:0] hop_addr;
      logic [15:0] hop_port;
   } entry_type;

   // one request item, unpacked
   typedef struct packed {
      op_type      op;
      logic [31:0] dest_addr;
      logic [5:0]  pfx_len;
      logic [31:0] hop_addr;
      logic [15:0] hop_port;
   } req_type;

   // one finished result offered by the sequencer
   typedef struct packed {
      logic        valid;
      status_type  status;
      logic [31:0] hop_addr;
      logic [15:0] hop_port;
   } res_type;

   // mask from prefix length; lengths above 32 saturate, zero gives no bits
   function automatic logic [31:0] make_mask(input logic [5:0] plen);
      logic [5:0] n;
      begin
         n = (plen > 6'd32) ? 6'd32 : plen;
         return ~(32'hFFFF_FFFF >> n);
      end
   endfunction

endpackage

`default_nettype wire

// ===== design/rtmf_mem.sv =====
// ----------------------------------------------------------------------------
// rtmf_mem
// Route storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rtmf_mem #(
   parameter int ENTRIES = 64,
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   rd_en,
   input  wire logic [IDX_W-1:0]       rd_idx,
   output rtmf_pkg::entry_type         rd_data,
   input  wire logic                   wr_en,
   input  wire logic [IDX_W-1:0]       wr_idx,
   input  wire rtmf_pkg::entry_type    wr_data
);

   rtmf_pkg::entry_type route_mem [ENTRIES];
   rtmf_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         route_mem[wr_idx] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= route_mem[rd_idx];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/rtmf_ctrl.sv =====
// ----------------------------------------------------------------------------
// rtmf_ctrl
// Sequencer: scans the route memory, then updates, appends, deletes or swaps.
// ----------------------------------------------------------------------------
`default_nettype none

module rtmf_ctrl #(
   parameter int ENTRIES = 64,
   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
   localparam int CNT_W = $clog2(ENTRIES + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire rtmf_pkg::req_type      req,
   output rtmf_pkg::res_type           res,
   input  wire logic                   res_ready,
   output logic [CNT_W-1:0]            route_count,
   output logic                        mem_rd_en,
   output logic [IDX_W-1:0]            mem_rd_idx,
   input  wire rtmf_pkg::entry_type    mem_rd_data,
   output logic                        mem_wr_en,
   output logic [IDX_W-1:0]            mem_wr_idx,
   output rtmf_pkg::entry_type         mem_wr_data
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_SET_WR,
      S_DEL_RD,
      S_DEL_WR,
      S_SWAP_RD,
      S_SWAP_HI,
      S_SWAP_LO,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]       chk_idx_ff, chk_idx_in;
   logic [CNT_W-1:0]       slot_ff, slot_in;
   rtmf_pkg::op_type       op_ff, op_in;
   logic [31:0]            addr_ff, addr_in;
   logic [31:0]            net_ff, net_in;
   logic [31:0]            mask_ff, mask_in;
   logic [31:0]            hop_a_ff, hop_a_in;
   logic [15:0]            hop_p_ff, hop_p_in;
   rtmf_pkg::entry_type    hit_ff, hit_in;
   rtmf_pkg::status_type   status_ff, status_in;
   logic [31:0]            res_a_ff, res_a_in;
   logic [15:0]            res_p_ff, res_p_in;
   logic [31:0]            new_mask;
   logic [CNT_W-1:0]       last_idx;
   logic                   match;

   assign new_mask = rtmf_pkg::make_mask(req.pfx_len);
   assign last_idx = count_ff - 1'b1;

   // compare the entry read in the previous cycle
   always_comb begin
      if (op_ff == rtmf_pkg::OP_LOOK) begin
         match = chk_vld_ff && (mem_rd_data.net == (addr_ff & mem_rd_data.mask));
      end else begin
         match = chk_vld_ff && (mem_rd_data.net == net_ff)
                 && (mem_rd_data.mask == mask_ff);
      end
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      chk_vld_in  = 1'b0;
      chk_idx_in  = chk_idx_ff;
      slot_in     = slot_ff;
      op_in       = op_ff;
      addr_in     = addr_ff;
      net_in      = net_ff;
      mask_in     = mask_ff;
      hop_a_in    = hop_a_ff;
      hop_p_in    = hop_p_ff;
      hit_in      = hit_ff;
      status_in   = status_ff;
      res_a_in    = res_a_ff;
      res_p_in    = res_p_ff;
      mem_rd_en   = 1'b0;
      mem_rd_idx  = rd_idx_ff[IDX_W-1:0];
      mem_wr_en   = 1'b0;
      mem_wr_idx  = slot_ff[IDX_W-1:0];
      mem_wr_data = '{net: net_ff, mask: mask_ff, hop_addr: hop_a_ff, hop_port: hop_p_ff};

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req.op;
               addr_in   = req.dest_addr;
               mask_in   = new_mask;
               net_in    = req.dest_addr & new_mask;
               hop_a_in  = req.hop_addr;
               hop_p_in  = req.hop_port;
               status_in = rtmf_pkg::STATUS_MISS;
               res_a_in  = '0;
               res_p_in  = '0;
               rd_idx_in = '0;
               state_in  = (req.op == rtmf_pkg::OP_NONE) ? S_DONE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (match) begin
               slot_in   = CNT_W'(chk_idx_ff);
               hit_in    = mem_rd_data;
               status_in = rtmf_pkg::STATUS_OK;
               case (op_ff)
                  rtmf_pkg::OP_SET: state_in = S_SET_WR;
                  rtmf_pkg::OP_DEL: state_in = S_DEL_RD;
                  rtmf_pkg::OP_LOOK: begin
                     res_a_in = mem_rd_data.hop_addr;
                     res_p_in = mem_rd_data.hop_port;
                     state_in = (chk_idx_ff == '0) ? S_DONE : S_SWAP_RD;
                  end
                  default: state_in = S_DONE;
               endcase
            end else if (rd_idx_ff < count_ff) begin
               // issue the next read; its compare lands in the following cycle
               mem_rd_en  = 1'b1;
               chk_vld_in = 1'b1;
               chk_idx_in = rd_idx_ff[IDX_W-1:0];
               rd_idx_in  = rd_idx_ff + 1'b1;
            end else if (!chk_vld_ff) begin
               // scan exhausted without a match
               if (op_ff == rtmf_pkg::OP_SET) begin
                  if (count_ff == CNT_W'(ENTRIES)) begin
                     status_in = rtmf_pkg::STATUS_FULL;
                     state_in  = S_DONE;
                  end else begin
                     slot_in   = count_ff;
                     status_in = rtmf_pkg::STATUS_OK;
                     state_in  = S_SET_WR;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SET_WR: begin
            mem_wr_en = 1'b1;
            if (slot_ff == count_ff) begin
               count_in = count_ff + 1'b1;
            end
            state_in = S_DONE;
         end
         S_DEL_RD: begin
            mem_rd_en  = 1'b1;
            mem_rd_idx = last_idx[IDX_W-1:0];
            state_in   = S_DEL_WR;
         end
         S_DEL_WR: begin
            // move the last entry into the freed slot
            mem_wr_en   = 1'b1;
            mem_wr_data = mem_rd_data;
            count_in    = last_idx;
            state_in    = S_DONE;
         end
         S_SWAP_RD: begin
            mem_rd_en  = 1'b1;
            mem_rd_idx = '0;
            state_in   = S_SWAP_HI;
         end
         S_SWAP_HI: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = mem_rd_data;
            state_in    = S_SWAP_LO;
         end
         S_SWAP_LO: begin
            mem_wr_en   = 1'b1;
            mem_wr_idx  = '0;
            mem_wr_data = hit_ff;
            state_in    = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         chk_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         chk_vld_ff <= chk_vld_in;
      end
      rd_idx_ff  <= rd_idx_in;
      chk_idx_ff <= chk_idx_in;
      slot_ff    <= slot_in;
      op_ff      <= op_in;
      addr_ff    <= addr_in;
      net_ff     <= net_in;
      mask_ff    <= mask_in;
      hop_a_ff   <= hop_a_in;
      hop_p_ff   <= hop_p_in;
      hit_ff     <= hit_in;
      status_ff  <= status_in;
      res_a_ff   <= res_a_in;
      res_p_ff   <= res_p_in;
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign res.valid    = (state_ff == S_DONE);
   assign res.status   = status_ff;
   assign res.hop_addr = res_a_ff;
   assign res.hop_port = res_p_ff;
   assign route_count  = count_ff;

endmodule

`default_nettype wire

// ===== design/route_table_move_to_front.sv =====
// ----------------------------------------------------------------------------
// route_table_move_to_front
// Linear route table with exact-match set/delete and move-to-front lookup.
// ----------------------------------------------------------------------------
//
//   channel | direction | tuser                 | tdata (low bit up)
//   --------+-----------+-----------------------+-----------------------------
//   req_    | in        | [1:0] operation       | dest_addr, pfx_len,
//           |           |                       | hop_addr_in, hop_port_in
//   rsp_    | out       | [1:0] status          | hop_addr_out, hop_port_out
//
// Timing: the scan reads one entry a cycle through the single read port of
//   the route memory and stops at the first match. A miss, or a set on a
//   full table, ends after the scan; an update or an append then writes one
//   slot; a delete reads the last entry and writes it into the freed slot;
//   a lookup that hits past slot 0 swaps the hit route with slot 0. The
//   result shows on rsp_ in the first cycle that a next item may be accepted.
// Reset: synchronous, clears the sequencer and the route count; the memory
//   itself is not cleared, only slots below the count are ever read.
// Stalls: a finished result waits in the output register; the sequencer
//   holds its result while that register is full and not taken.
//
`default_nettype none
`include "assert_macros.svh"

module route_table_move_to_front #(
   parameter int ENTRIES = 64
) (
   input  wire logic          clock,
   input  wire logic          reset,
   // request: tdata = dest_addr[31:0], pfx_len[37:32],
   //          hop_addr_in[69:38], hop_port_in[85:70], zero pad [87:86]
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [87:0]   req_tdata,
   input  wire logic [1:0]    req_tuser,   // operation [1:0]
   // response: tdata = hop_addr_out[31:0], hop_port_out[47:32]
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [47:0]        rsp_tdata,
   output logic [1:0]         rsp_tuser    // status [1:0]
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   rtmf_pkg::req_type      req;
   rtmf_pkg::res_type      res;
   logic                   res_ready;
   logic [CNT_W-1:0]       route_count;
   logic                   mem_rd_en;
   logic [IDX_W-1:0]       mem_rd_idx;
   rtmf_pkg::entry_type    mem_rd_data;
   logic                   mem_wr_en;
   logic [IDX_W-1:0]       mem_wr_idx;
   rtmf_pkg::entry_type    mem_wr_data;

   // output register
   logic                   rsp_vld_ff, rsp_vld_in;
   rtmf_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [31:0]            rsp_addr_ff, rsp_addr_in;
   logic [15:0]            rsp_port_ff, rsp_port_in;

   // unpack the request item
   assign req.op        = rtmf_pkg::op_type'(req_tuser);
   assign req.dest_addr = req_tdata[31:0];
   assign req.pfx_len   = req_tdata[37:32];
   assign req.hop_addr  = req_tdata[69:38];
   assign req.hop_port  = req_tdata[85:70];

   rtmf_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req         (req),
      .res         (res),
      .res_ready   (res_ready),
      .route_count (route_count),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_idx  (mem_rd_idx),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_idx  (mem_wr_idx),
      .mem_wr_data (mem_wr_data)
   );

   rtmf_mem #(
      .ENTRIES (ENTRIES)
   ) u_mem (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_idx  (mem_rd_idx),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_idx  (mem_wr_idx),
      .wr_data (mem_wr_data)
   );

   // take a new result when the register is empty or being drained
   assign res_ready = !rsp_vld_ff || rsp_tready;

   always_comb begin
      rsp_vld_in    = rsp_vld_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_port_in   = rsp_port_ff;
      if (res_ready) begin
         // load the pending result, or drop the drained one
         rsp_vld_in    = res.valid;
         rsp_status_in = res.status;
         rsp_addr_in   = res.hop_addr;
         rsp_port_in   = res.hop_port;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_port_ff   <= rsp_port_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_port_ff, rsp_addr_ff};

   // the table never holds more routes than it has slots
   `RTMF_CHECK(a_count_bound, clock, reset, route_count <= CNT_W'(ENTRIES))
   // an accepted item keeps the block busy for at least the next cycle
   `RTMF_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   // a finished result is held while the output register is blocked
   `RTMF_NEXT(a_hold_result, clock, reset, res.valid && rsp_vld_ff && !rsp_tready, res.valid)

endmodule

`default_nettype wire

// ===== tb/tb_route_table_move_to_front.sv =====
// ----------------------------------------------------------------------------
// tb_route_table_move_to_front
// Runs set, delete and look-up items through the route table and checks
// each reply against a route table kept in the bench. Directed cases come
// first, then the table is filled and the reply side is held off, then
// about a thousand random items run with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_route_table_move_to_front;

   localparam int ENTRIES     = 64;
   localparam int LONG_HOLD   = 300;       // reply-side hold-off, in cycles
   localparam int DRAIN_LIMIT = 5000;      // cycles to wait for late replies
   localparam int SETTLE      = ENTRIES + 10;

   // one reply as the bench expects it
   typedef struct {
      rtmf_pkg::status_type status;
      logic [31:0]          hop_addr;
      logic [15:0]          hop_port;
   } route_reply_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   // hop_port_in, hop_addr_in, pfx_len, dest_addr (high bits first)
   logic [87:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = rtmf_pkg::OP_NONE;     // operation
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [47:0] rsp_tdata;               // hop_addr_out [31:0], hop_port_out [47:32]
   wire  [1:0]  rsp_tuser;               // status

   // bench copy of the route table
   logic [31:0] tbl_net      [ENTRIES];
   logic [31:0] tbl_mask     [ENTRIES];
   logic [31:0] tbl_hop_addr [ENTRIES];
   logic [15:0] tbl_hop_port [ENTRIES];
   int          tbl_count = 0;

   route_reply_type route_replies[$];    // replies still owed by the block
   int              mismatch_count = 0;
   bit              req_idle_on = 1'b1;
   bit              rsp_idle_on = 1'b1;
   bit              hold_rsp    = 1'b0;

   route_table_move_to_front #(.ENTRIES(ENTRIES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Route table predictor
   // ---------------------------------------------------------------------

   // zero length gives no bits, lengths of 32 and above give all bits
   function automatic logic [31:0] prefix_mask(input logic [5:0] plen);
      if (plen == 6'd0)
         return 32'h0;
      if (plen >= 6'd32)
         return 32'hFFFF_FFFF;
      return 32'hFFFF_FFFF << (32 - int'(plen));
   endfunction

   // slot holding exactly this net and mask, or -1
   function automatic int locate_route(input logic [31:0] net, input logic [31:0] mask);
      for (int i = 0; i < tbl_count; i++)
         if (tbl_net[i] == net && tbl_mask[i] == mask)
            return i;
      return -1;
   endfunction

   // apply one item to the bench table and return the reply it owes
   function automatic route_reply_type apply_route_op(input rtmf_pkg::op_type op,
                                                      input logic [31:0] addr,
                                                      input logic [5:0] plen,
                                                      input logic [31:0] hop_a,
                                                      input logic [15:0] hop_p);
      route_reply_type r;
      logic [31:0]     mask;
      logic [31:0]     net;
      logic [31:0]     t_net, t_mask, t_addr;
      logic [15:0]     t_port;
      int              slot;
      int              last;
      r.status   = rtmf_pkg::STATUS_MISS;
      r.hop_addr = '0;
      r.hop_port = '0;
      mask = prefix_mask(plen);
      net  = addr & mask;
      case (op)
         rtmf_pkg::OP_SET: begin
            slot = locate_route(net, mask);
            if (slot >= 0) begin
               // update in place, the route keeps its slot
               tbl_hop_addr[slot] = hop_a;
               tbl_hop_port[slot] = hop_p;
               r.status = rtmf_pkg::STATUS_OK;
            end else if (tbl_count >= ENTRIES) begin
               r.status = rtmf_pkg::STATUS_FULL;
            end else begin
               tbl_net[tbl_count]      = net;
               tbl_mask[tbl_count]     = mask;
               tbl_hop_addr[tbl_count] = hop_a;
               tbl_hop_port[tbl_count] = hop_p;
               tbl_count++;
               r.status = rtmf_pkg::STATUS_OK;
            end
         end
         rtmf_pkg::OP_DEL: begin
            slot = locate_route(net, mask);
            if (slot >= 0) begin
               // fill the hole with the last route
               last = tbl_count - 1;
               tbl_net[slot]      = tbl_net[last];
               tbl_mask[slot]     = tbl_mask[last];
               tbl_hop_addr[slot] = tbl_hop_addr[last];
               tbl_hop_port[slot] = tbl_hop_port[last];
               tbl_count = last;
               r.status  = rtmf_pkg::STATUS_OK;
            end
         end
         rtmf_pkg::OP_LOOK: begin
            // first match in stored order wins and moves to slot 0
            for (int i = 0; i < tbl_count; i++) begin
               if (tbl_net[i] == (addr & tbl_mask[i])) begin
                  t_net           = tbl_net[0];
                  tbl_net[0]      = tbl_net[i];
                  tbl_net[i]      = t_net;
                  t_mask          = tbl_mask[0];
                  tbl_mask[0]     = tbl_mask[i];
                  tbl_mask[i]     = t_mask;
                  t_addr          = tbl_hop_addr[0];
                  tbl_hop_addr[0] = tbl_hop_addr[i];
                  tbl_hop_addr[i] = t_addr;
                  t_port          = tbl_hop_port[0];
                  tbl_hop_port[0] = tbl_hop_port[i];
                  tbl_hop_port[i] = t_port;
                  r.hop_addr = tbl_hop_addr[0];
                  r.hop_port = tbl_hop_port[0];
                  r.status   = rtmf_pkg::STATUS_OK;
                  break;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side: send one item, predict its reply on acceptance
   // ---------------------------------------------------------------------
   task automatic send_route_item(input rtmf_pkg::op_type op, input logic [31:0] addr,
                                  input logic [5:0] plen, input logic [31:0] hop_a,
                                  input logic [15:0] hop_p);
      int gap;
      // drop valid for a random burst now and then
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, hop_p, hop_a, plen, addr};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      // valid stays high; a random gap in the next call or the end of the run lowers it
      route_replies.insert(route_replies.size(), apply_route_op(op, addr, plen, hop_a, hop_p));
   endtask

   // ---------------------------------------------------------------------
   // Reply side: random stalls, plus one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin : rsp_pacer
      int gap;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            // hold off long enough for the block to back up into its input
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_tready <= 1'b1;
            hold_rsp = 1'b0;
         end else if (!reset && rsp_idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // compare each accepted reply with the oldest owed one
   always @(posedge clock) begin
      route_reply_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (route_replies.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: reply with none owed: status %0d hop %h:%h",
                        $realtime, rsp_tuser, rsp_tdata[31:0], rsp_tdata[47:32]);
         end else begin
            e = route_replies[0];
            route_replies.delete(0);
            if (rsp_tuser !== e.status || rsp_tdata[31:0] !== e.hop_addr ||
                rsp_tdata[47:32] !== e.hop_port) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"%0t: reply mismatch: status exp %0d got %0d, ",
                            "hop_addr exp %h got %h, hop_port exp %h got %h"},
                           $realtime, e.status, rsp_tuser, e.hop_addr, rsp_tdata[31:0],
                           e.hop_port, rsp_tdata[47:32]);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // an address that falls inside the route in this slot
   function automatic logic [31:0] addr_in_route(input int slot);
      return tbl_net[slot] | ($urandom & ~tbl_mask[slot]);
   endfunction

   // mostly ordinary prefixes, now and then zero or an oversized length
   function automatic logic [5:0] random_prefix();
      int pick;
      pick = $urandom_range(0, 39);
      if (pick == 0)
         return 6'd0;
      if (pick < 4)
         return 6'($urandom_range(33, 63));
      return 6'($urandom_range(1, 32));
   endfunction

   // prefix length of a stored route, sometimes written oversized
   function automatic logic [5:0] route_prefix(input int slot);
      logic [5:0] plen;
      plen = 6'($countones(tbl_mask[slot]));
      if (plen == 6'd32 && $urandom_range(0, 2) == 0)
         plen = 6'($urandom_range(33, 63));
      return plen;
   endfunction

   // one random item; weights in percent, the rest go to look-ups but for 2 percent unused-code items
   task automatic send_random_route_item(input int set_pct, input int del_pct);
      int         pick;
      int         slot;
      logic [31:0] addr;
      logic [5:0]  plen;
      pick = $urandom_range(0, 99);
      slot = (tbl_count > 0) ? $urandom_range(0, tbl_count - 1) : 0;
      if (pick < set_pct) begin
         if (tbl_count > 0 && $urandom_range(0, 3) == 0) begin
            addr = addr_in_route(slot);
            plen = route_prefix(slot);
         end else begin
            addr = $urandom;
            plen = random_prefix();
         end
         send_route_item(rtmf_pkg::OP_SET, addr, plen, $urandom, 16'($urandom));
      end else if (pick < set_pct + del_pct) begin
         if (tbl_count > 0 && $urandom_range(0, 2) != 0) begin
            addr = addr_in_route(slot);
            plen = route_prefix(slot);
         end else begin
            addr = $urandom;
            plen = random_prefix();
         end
         send_route_item(rtmf_pkg::OP_DEL, addr, plen, $urandom, 16'($urandom));
      end else if (pick < 98) begin
         addr = (tbl_count > 0 && $urandom_range(0, 4) != 0) ? addr_in_route(slot) : $urandom;
         send_route_item(rtmf_pkg::OP_LOOK, addr, 6'($urandom), $urandom, 16'($urandom));
      end else begin
         send_route_item(rtmf_pkg::OP_NONE, $urandom, 6'($urandom), $urandom,
                         16'($urandom));
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // field extremes, every operation and the named corner cases
   task automatic test_directed();
      // empty miss, delete miss, unused code
      send_route_item(rtmf_pkg::OP_LOOK, 32'h0000_0000, 6'd0,  32'h0, 16'h0);
      send_route_item(rtmf_pkg::OP_DEL,  32'h0000_0000, 6'd0,  32'h0, 16'h0);
      send_route_item(rtmf_pkg::OP_NONE, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 16'hFFFF);
      send_route_item(rtmf_pkg::OP_SET,  32'hFFFF_FFFF, 6'd32, 32'hFFFF_FFFF, 16'hFFFF);
      send_route_item(rtmf_pkg::OP_SET,  32'h0A12_3456, 6'd8,  32'h0102_0304, 16'h0000);
      // hit in slot 0, then a hit that swaps
      send_route_item(rtmf_pkg::OP_LOOK, 32'hFFFF_FFFF, 6'd0,  32'h0, 16'h0);
      send_route_item(rtmf_pkg::OP_LOOK, 32'h0A77_0001, 6'd5,  32'h0, 16'h0);
      // oversized length saturates and updates in place
      send_route_item(rtmf_pkg::OP_SET,  32'hFFFF_FFFF, 6'd63, 32'h0000_0000, 16'h0001);
      send_route_item(rtmf_pkg::OP_LOOK, 32'hFFFF_FFFF, 6'd63, 32'h0, 16'h0);
      // default route
      send_route_item(rtmf_pkg::OP_SET,  32'h1234_5678, 6'd0,  32'hAAAA_5555, 16'h5A5A);
      send_route_item(rtmf_pkg::OP_LOOK, 32'h0000_0000, 6'd0,  32'h0, 16'h0);
      send_route_item(rtmf_pkg::OP_LOOK, 32'h0B00_0000, 6'd0,  32'h0, 16'h0);
      // delete hit, then the same delete misses, then drop the default
      send_route_item(rtmf_pkg::OP_DEL,  32'h0A00_FFFF, 6'd8,  32'h0, 16'h0);
      send_route_item(rtmf_pkg::OP_DEL,  32'h0A00_0000, 6'd8,  32'h0, 16'h0);
      send_route_item(rtmf_pkg::OP_DEL,  32'hDEAD_BEEF, 6'd0,  32'h0, 16'h0);
      send_route_item(rtmf_pkg::OP_LOOK, 32'h0B00_0000, 6'd0,  32'h0, 16'h0);
      // first match wins, not the longest
      send_route_item(rtmf_pkg::OP_SET,  32'hC0A8_0100, 6'd24, 32'h5555_AAAA, 16'hA5A5);
      send_route_item(rtmf_pkg::OP_SET,  32'hC0A8_0180, 6'd25, 32'h0F0F_0F0F, 16'hF0F0);
      send_route_item(rtmf_pkg::OP_LOOK, 32'hC0A8_01C1, 6'd32, 32'h0, 16'h0);
      send_route_item(rtmf_pkg::OP_NONE, 32'h0000_0000, 6'd0,  32'h0, 16'h0);
      // the last route moves into the freed slot
      send_route_item(rtmf_pkg::OP_DEL,  32'hFFFF_FFFF, 6'd32, 32'h0, 16'h0);
      send_route_item(rtmf_pkg::OP_LOOK, 32'hC0A8_0181, 6'd0,  32'h0, 16'h0);
   endtask

   // fill every slot, then push against the full table
   task automatic test_table_full();
      while (tbl_count < ENTRIES)
         send_route_item(rtmf_pkg::OP_SET, $urandom, 6'($urandom_range(1, 32)), $urandom,
                         16'($urandom));
      repeat (3)
         send_route_item(rtmf_pkg::OP_SET, $urandom, 6'd32, $urandom, 16'($urandom));
      // update while full
      send_route_item(rtmf_pkg::OP_SET, addr_in_route(ENTRIES - 1),
                      route_prefix(ENTRIES - 1), $urandom, 16'($urandom));
      send_route_item(rtmf_pkg::OP_LOOK, addr_in_route(ENTRIES - 1), 6'd0, 32'h0, 16'h0);
      send_route_item(rtmf_pkg::OP_DEL, addr_in_route(0), route_prefix(0), 32'h0, 16'h0);
      send_route_item(rtmf_pkg::OP_SET, $urandom, 6'd32, $urandom, 16'($urandom));
   endtask

   // hold the reply side off while items keep coming
   task automatic test_reply_backpressure();
      req_idle_on = 1'b0;
      hold_rsp    = 1'b1;
      repeat (12)
         send_random_route_item(10, 10);
      req_idle_on = 1'b1;
   endtask

   // long random run in segments that grow, shrink or churn the table
   task automatic test_random_mix();
      for (int seg = 0; seg < 10; seg++) begin
         // no idling in the last stretch, random on or off before it
         req_idle_on = (seg < 8) && ($urandom_range(0, 3) != 0);
         rsp_idle_on = (seg < 8) && ($urandom_range(0, 3) != 0);
         repeat (100) begin
            case (seg % 3)
               0:       send_random_route_item(60, 10);
               1:       send_random_route_item(15, 50);
               default: send_random_route_item(35, 30);
            endcase
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_seq
      int waited;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_table_full();
      test_reply_backpressure();
      test_random_mix();

      req_tvalid <= 1'b0;

      // drain owed replies, then let the block settle
      waited = 0;
      while (route_replies.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE) @(posedge clock);
      if (route_replies.size() != 0) begin
         mismatch_count += route_replies.size();
         $display("%0d replies never arrived", route_replies.size());
      end

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // hard stop well beyond the slowest correct run
   initial begin : watchdog
      #12_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
